>>> hw/rtl/lnzr_pkg.sv
// ----------------------------------------------------------------------------
// lnzr_pkg: shared types for the line resampler
// Pixel and tap word layouts passed between the store, the MAC unit and the
// sequencer, and the action codes carried by an input word.
// ----------------------------------------------------------------------------
package lnzr_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned PIX_W    = 3 * CH_W;

  // What an input word asks the block to do.
  typedef enum logic [1:0] {
    ACT_PIXEL   = 2'd0,
    ACT_TAP     = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // One pixel and its tap weight, as read together from the two stores.
  typedef struct packed {
    logic                       valid;
    rgb_t                       pix;
    logic signed [WEIGHT_W-1:0] weight;
  } tap_pair_t;

endpackage

>>> hw/rtl/lnzr_store.sv
// ----------------------------------------------------------------------------
// lnzr_store: line store and tap store
// Two single-write, single-read memories with registered read data. A read
// fetches one source pixel and one tap weight in the same cycle.
// ----------------------------------------------------------------------------
module lnzr_store #(
  parameter int unsigned LINE_MAX = 4096,
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pix_we,
  input  logic [$clog2(LINE_MAX)-1:0]      pix_waddr,
  input  lnzr_pkg::rgb_t                   pix_wdata,
  input  logic                             tap_we,
  input  logic [$clog2(MAX_TAPS)-1:0]      tap_waddr,
  input  logic signed [lnzr_pkg::WEIGHT_W-1:0] tap_wdata,
  input  logic                             rd_en,
  input  logic [$clog2(LINE_MAX)-1:0]      rd_line_addr,
  input  logic [$clog2(MAX_TAPS)-1:0]      rd_tap_addr,
  output lnzr_pkg::tap_pair_t              rd_q
);
  import lnzr_pkg::*;

  rgb_t                       line_mem [LINE_MAX];
  logic signed [WEIGHT_W-1:0] tap_mem  [MAX_TAPS];

  rgb_t                       pix_q_r;
  logic signed [WEIGHT_W-1:0] weight_q_r;
  logic                       valid_r;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      line_mem[pix_waddr] <= pix_wdata;
    end
    if (rd_en) begin
      pix_q_r <= line_mem[rd_line_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    if (rd_en) begin
      weight_q_r <= tap_mem[rd_tap_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rd_en;
    end
  end

  assign rd_q = '{valid: valid_r, pix: pix_q_r, weight: weight_q_r};

endmodule

>>> hw/rtl/lnzr_mac.sv
// ----------------------------------------------------------------------------
// lnzr_mac: three-lane multiply-accumulate unit
// One product per color channel per cycle, registered, then added into a
// wide accumulator that starts at the rounding offset. Rounding and clamping
// of the result to 0..255 is done on the accumulator output.
// ----------------------------------------------------------------------------
module lnzr_mac #(
  parameter int unsigned MAX_TAPS  = 64,
  parameter int unsigned FRAC_BITS = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  lnzr_pkg::tap_pair_t pair,
  output lnzr_pkg::rgb_t      result
);
  import lnzr_pkg::*;

  localparam int unsigned PROD_W = CH_W + 1 + WEIGHT_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic [CH_W-1:0]          ch     [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r  [3];
  logic [CH_W-1:0]          sat    [3];

  assign ch[0] = pair.pix.red;
  assign ch[1] = pair.pix.green;
  assign ch[2] = pair.pix.blue;

  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] q;
    q = ACC_W'(acc >>> FRAC_BITS);
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (q > ACC_W'(255)) begin
      return '1;
    end else begin
      return CH_W'(q);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= PROD_W'($signed({1'b0, ch[c]}) * pair.weight);
      if (clear) begin
        acc_r[c] <= ROUND;
      end else if (prod_v_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat[c] = clamp_ch(acc_r[c]);
    end
  end

  assign result = '{red: sat[0], green: sat[1], blue: sat[2]};

endmodule

>>> hw/rtl/lanczos_line_resampler.sv
// ----------------------------------------------------------------------------
// lanczos_line_resampler: one pass of a separable Lanczos3 resampler
// Pixel and tap writes land in two stores; a compute word walks its window
// through a shared three-lane MAC and returns one rounded, clamped RGB word.
// ----------------------------------------------------------------------------
// Sequencing: a compute word goes through ST_REDUCE, which brings window_start
//   into the line by subtracting LINE_MAX, then ST_RUN, which reads the taps,
//   then ST_DRAIN and ST_FINISH, which waits for room in the output register.
// Throughput: a new word is taken only once the sequencer is back in idle;
//   the single MAC takes one tap per cycle; writes go one per cycle when idle.
// Reset: synchronous, active low; clears the sequencer and the output valid.
//   Store contents are undefined until written and are never cleared.
// ----------------------------------------------------------------------------
module lanczos_line_resampler #(
  parameter int unsigned LINE_MAX  = 4096,
  parameter int unsigned MAX_TAPS  = 64,
  parameter int unsigned FRAC_BITS = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [11:0]        in_pixel_position,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [5:0]         in_tap_index,
  input  logic signed [23:0] in_tap_weight,
  input  logic [11:0]        in_window_start,
  input  logic [6:0]         in_tap_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);
  import lnzr_pkg::*;

  localparam int unsigned LA = $clog2(LINE_MAX);
  localparam int unsigned TA = $clog2(MAX_TAPS);
  localparam int unsigned CW = $clog2(MAX_TAPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [11:0]     start_r, start_nxt;
  logic [LA-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  rgb_t            out_pix_r, out_pix_nxt;

  logic            pix_we, tap_we, rd_en, mac_clear;
  tap_pair_t       tap_q;
  rgb_t            mac_result;
  action_t         act;

  assign act = action_t'(in_action);

  lnzr_store #(
    .LINE_MAX(LINE_MAX),
    .MAX_TAPS(MAX_TAPS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_we      (pix_we),
    .pix_waddr   (LA'(in_pixel_position)),
    .pix_wdata   ('{red: in_red, green: in_green, blue: in_blue}),
    .tap_we      (tap_we),
    .tap_waddr   (TA'(in_tap_index)),
    .tap_wdata   (in_tap_weight),
    .rd_en       (rd_en),
    .rd_line_addr(pos_r),
    .rd_tap_addr (i_r[TA-1:0]),
    .rd_q        (tap_q)
  );

  lnzr_mac #(
    .MAX_TAPS (MAX_TAPS),
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (mac_clear),
    .pair  (tap_q),
    .result(mac_result)
  );

  // The block takes a word only between compute jobs; a finished result can
  // still sit in the output register while writes come in.
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    count_nxt     = count_r;
    out_pix_nxt   = out_pix_r;
    out_valid_nxt = out_valid_r && out_stall;
    pix_we        = 1'b0;
    tap_we        = 1'b0;
    rd_en         = 1'b0;
    mac_clear     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (act)
            ACT_PIXEL: begin
              // Positions beyond the line are dropped.
              pix_we = (32'(in_pixel_position) < 32'(LINE_MAX));
            end
            ACT_TAP: begin
              tap_we = (32'(in_tap_index) < 32'(MAX_TAPS));
            end
            ACT_COMPUTE: begin
              start_nxt = in_window_start;
              // A tap count above the tap store depth uses the whole store.
              if (32'(in_tap_count) > 32'(MAX_TAPS)) begin
                count_nxt = CW'(MAX_TAPS);
              end else begin
                count_nxt = CW'(in_tap_count);
              end
              mac_clear = 1'b1;
              state_nxt = ST_REDUCE;
            end
            ACT_NONE: begin
            end
          endcase
        end
      end
      ST_REDUCE: begin
        // Bring the window start into the line by repeated subtraction; a start
        // that already lies inside it is used as it is.
        if (32'(start_r) >= 32'(LINE_MAX)) begin
          start_nxt = start_r - 12'(LINE_MAX);
        end else begin
          pos_nxt   = LA'(start_r);
          i_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (i_r < count_r) begin
          rd_en = 1'b1;
          i_nxt = i_r + 1'b1;
          // Windows that run past the line end wrap to its beginning.
          if (32'(pos_r) == 32'(LINE_MAX - 1)) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last product reaches the accumulator during this cycle.
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = mac_result;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      count_r     <= count_nxt;
    end
    start_r   <= start_nxt;
    pos_r     <= pos_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r.red;
  assign out_green = out_pix_r.green;
  assign out_blue  = out_pix_r.blue;

  // A compute word always takes the block out of its idle state.
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_COMPUTE |=> in_stall)
    else $error("compute word accepted but block stayed ready");

  // A new result only ever comes from the finish step of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish step");

  // The tap counter never runs past the requested count.
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> i_r <= count_r)
    else $error("tap counter beyond tap count");

  // No tap is still in flight when the accumulator is sampled.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> !tap_q.valid && !rd_en)
    else $error("result taken with taps still in flight");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the Lanczos line resampler
// Loads the pixel line and the tap weights, then asks for resampled pixels.
// A predictor in this file keeps its own copy of both stores, so it knows the
// rounded, clamped RGB word that each compute request must return. Both sides
// of the valid/stall handshake idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lnzr_pkg::*;

  localparam int          LINE_LEN     = 4096;
  localparam int          TAP_SLOTS    = 64;
  localparam int          FRAC         = 22;
  localparam longint      ROUND_HALF   = 64'sd1 << (FRAC - 1);
  localparam int          ITEM_TARGET  = 1450;
  localparam int          CYCLE_LIMIT  = 800_000;
  // A full window is 64 taps; END_SETTLE leaves margin to watch for stray results.
  localparam int          END_SETTLE   = 100;
  localparam int          LONG_HOLD    = 400;
  localparam logic signed [23:0] W_MIN   = 24'sh800000;
  localparam logic signed [23:0] W_MAX   = 24'sh7FFFFF;
  localparam logic signed [23:0] W_UNITY = 24'sh400000;

  typedef enum int {WS_SMOOTH, WS_RANDOM, WS_EXTREME} weight_style_t;

  // One word on the input channel, with every field present whatever the action.
  typedef struct {
    action_t            action;
    logic [11:0]        position;
    rgb_t               color;
    logic [5:0]         tap_index;
    logic signed [23:0] weight;
    logic [11:0]        start;
    logic [6:0]         count;
  } word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic [11:0]        in_pixel_position;
  logic [7:0]         in_red;
  logic [7:0]         in_green;
  logic [7:0]         in_blue;
  logic [5:0]         in_tap_index;
  logic signed [23:0] in_tap_weight;
  logic [11:0]        in_window_start;
  logic [6:0]         in_tap_count;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;

  // Predictor state: our own copy of both stores and which tap slots hold data.
  rgb_t               line_copy    [LINE_LEN];
  logic signed [23:0] tap_copy     [TAP_SLOTS];
  bit                 tap_written  [TAP_SLOTS];
  rgb_t               expected_pixels[$];

  int send_gap_max    = 0;
  int recv_gap_max    = 0;
  int hold_off_cycles = 0;
  int words_sent      = 0;
  int pixels_checked  = 0;
  int wrap_windows    = 0;
  int saturated_windows = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int input_held      = 0;
  int output_held     = 0;

  lanczos_line_resampler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_pixel_position(in_pixel_position),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_tap_index     (in_tap_index),
    .in_tap_weight    (in_tap_weight),
    .in_window_start  (in_window_start),
    .in_tap_count     (in_tap_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drops the fraction bits (the rounding offset is already in the sum) and clamps to the 8-bit channel range.
  function automatic logic [7:0] clamp_channel(longint acc);
    longint q;
    if (acc < 0) begin
      return 8'd0;
    end
    q = acc >>> FRAC;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Multiply-accumulate over the window, one tap per source position. The
  // tap count saturates at the size of the tap store, and positions wrap at
  // the end of the line.
  function automatic rgb_t resample_pixel(logic [11:0] start, logic [6:0] count);
    int                 taps;
    int                 pos;
    longint             acc_r;
    longint             acc_g;
    longint             acc_b;
    rgb_t               px;
    logic signed [23:0] wt;
    rgb_t               res;
    taps  = (count > TAP_SLOTS) ? TAP_SLOTS : int'(count);
    acc_r = ROUND_HALF;
    acc_g = ROUND_HALF;
    acc_b = ROUND_HALF;
    for (int i = 0; i < taps; i++) begin
      pos   = (int'(start) + i) % LINE_LEN;
      px    = line_copy[pos];
      wt    = tap_copy[i];
      acc_r += longint'(px.red)   * longint'(wt);
      acc_g += longint'(px.green) * longint'(wt);
      acc_b += longint'(px.blue)  * longint'(wt);
    end
    res.red   = clamp_channel(acc_r);
    res.green = clamp_channel(acc_g);
    res.blue  = clamp_channel(acc_b);
    return res;
  endfunction

  // Number of tap slots written contiguously from slot zero.
  function automatic int tap_span();
    int n;
    n = 0;
    while (n < TAP_SLOTS && tap_written[n]) n++;
    return n;
  endfunction

  // Updates the store copies for an accepted word, or queues its pixel.
  function automatic void record_word(word_t w);
    int taps;
    case (w.action)
      ACT_PIXEL: begin
        line_copy[w.position]    = w.color;
        words_sent++;
      end
      ACT_TAP: begin
        tap_copy[w.tap_index]    = w.weight;
        tap_written[w.tap_index] = 1'b1;
        words_sent++;
      end
      ACT_COMPUTE: begin
        taps = (w.count > TAP_SLOTS) ? TAP_SLOTS : int'(w.count);
        if (int'(w.start) + taps > LINE_LEN) wrap_windows++;
        if (w.count > TAP_SLOTS) saturated_windows++;
        expected_pixels = {expected_pixels, resample_pixel(w.start, w.count)};
        words_sent++;
      end
      default: begin
        // The reserved action is dropped by the block and returns nothing.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fields that the action does not use still carry random values, so the
  // block is seen to ignore them.
  function automatic word_t filler_word();
    word_t w;
    w.action    = ACT_NONE;
    w.position  = 12'($urandom_range(0, LINE_LEN - 1));
    w.color     = 24'($urandom_range(0, 24'hFFFFFF));
    w.tap_index = 6'($urandom_range(0, TAP_SLOTS - 1));
    w.weight    = 24'($urandom_range(0, 24'hFFFFFF));
    w.start     = 12'($urandom_range(0, LINE_LEN - 1));
    w.count     = 7'($urandom_range(0, 127));
    return w;
  endfunction

  function automatic rgb_t make_color();
    rgb_t c;
    c = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 4) == 0) c.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 4) == 0) c.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 4) == 0) c.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return c;
  endfunction

  // Smooth weights look like a real kernel: mostly small positive lobes with
  // some negative ones. Random and extreme weights drive the clamps.
  function automatic logic signed [23:0] make_weight(weight_style_t style);
    int v;
    case (style)
      WS_SMOOTH: begin
        v = $urandom_range(0, 2097152);
        if ($urandom_range(0, 3) == 0) v = -int'($urandom_range(0, 1048576));
      end
      WS_RANDOM: v = $urandom_range(0, 24'hFFFFFF);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = int'(W_MIN);
          1:       v = int'(W_MAX);
          2:       v = 0;
          3:       v = int'(W_UNITY);
          default: v = -1;
        endcase
      end
    endcase
    return v[23:0];
  endfunction

  // Offers one word after a random gap and holds it until the block takes it.
  task automatic send_word(word_t w);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action         <= w.action;
    in_pixel_position <= w.position;
    in_red            <= w.color.red;
    in_green          <= w.color.green;
    in_blue           <= w.color.blue;
    in_tap_index      <= w.tap_index;
    in_tap_weight     <= w.weight;
    in_window_start   <= w.start;
    in_tap_count      <= w.count;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    record_word(w);
  endtask

  task automatic send_pixel(int pos, rgb_t c);
    word_t w;
    w          = filler_word();
    w.action   = ACT_PIXEL;
    w.position = pos[11:0];
    w.color    = c;
    send_word(w);
  endtask

  task automatic send_tap(int idx, logic signed [23:0] wt);
    word_t w;
    w           = filler_word();
    w.action    = ACT_TAP;
    w.tap_index = idx[5:0];
    w.weight    = wt;
    send_word(w);
  endtask

  task automatic send_resample(int start, int count);
    word_t w;
    w        = filler_word();
    w.action = ACT_COMPUTE;
    w.start  = start[11:0];
    w.count  = count[6:0];
    send_word(w);
  endtask

  task automatic send_nop();
    word_t w;
    w = filler_word();
    send_word(w);
  endtask

  // Drops valid and waits until every queued pixel has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: both clamps, exact unity taps, a window that wraps the
  // line end, a zero tap count, the reserved action and the top tap slot.
  task automatic test_directed();
    send_gap_max = 0;
    recv_gap_max = 0;
    send_pixel(4094, rgb_t'{8'd0, 8'd0, 8'd0});
    send_pixel(4095, rgb_t'{8'd255, 8'd0, 8'd128});
    send_pixel(0, rgb_t'{8'd0, 8'd255, 8'd1});
    send_pixel(1, rgb_t'{8'd255, 8'd255, 8'd255});
    send_tap(0, W_MIN);
    send_tap(1, 24'sd0);
    send_tap(2, 24'sh200000);
    send_tap(3, W_MAX);
    // A full white pixel times the most negative weight clamps to zero.
    send_resample(1, 1);
    // The largest weight is almost two, so white clamps to 255.
    send_tap(0, W_MAX);
    send_resample(1, 1);
    // A unity tap must give the source pixel back exactly after rounding.
    send_tap(0, W_UNITY);
    send_resample(4095, 1);
    send_resample(4095, 2);
    send_resample(0, 0);
    send_resample(4095, 0);
    send_resample(4094, 4);
    send_nop();
    send_tap(63, -24'sd1);
    send_pixel(2048, rgb_t'{8'd128, 8'd127, 8'd64});
    wait_results_drained();
  endtask

  // All 64 taps loaded and a long run of pixels across the line end, then
  // full windows, including tap counts beyond the store that must saturate.
  task automatic test_full_window();
    send_gap_max = 3;
    recv_gap_max = 3;
    for (int i = 0; i < TAP_SLOTS; i++) send_tap(i, make_weight(WS_SMOOTH) >>> 3);
    for (int j = 0; j < 80; j++) send_pixel((4060 + j) % LINE_LEN, make_color());
    send_resample(4060, 64);
    send_resample(4076, 127);
    send_resample(4070, 65);
    send_resample(4061, 100);
    send_resample(4075, 64);
    send_tap(63, W_MAX);
    send_resample(4076, 127);
    send_tap(0, W_MIN);
    send_resample(4060, 64);
    wait_results_drained();
  endtask

  // The receiver holds off for a long stretch while computes keep coming, so
  // the block backs up and stalls its input. The sender then pauses until all
  // results are home before it carries on.
  task automatic test_backpressure();
    send_gap_max    = 0;
    recv_gap_max    = 2;
    hold_off_cycles = LONG_HOLD;
    for (int k = 0; k < 24; k++) begin
      send_resample($urandom_range(4060, 4076), $urandom_range(0, 127));
    end
    wait_results_drained();
    for (int k = 0; k < 4; k++) send_resample($urandom_range(4060, 4076), 64);
    wait_results_drained();
  endtask

  // Bursts shaped like real use: an occasional reload of the tap set, a run
  // of source pixels, then several computes over that run. Pixel and tap
  // rewrites just ahead of a compute, stray writes and reserved words are
  // mixed in as noise.
  task automatic test_random_bursts();
    int            span;
    int            len;
    int            base;
    int            max_count;
    int            count;
    int            taps;
    int            start;
    int            bursts;
    weight_style_t style;
    bursts = 0;
    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       send_gap_max = 0;
        1:       send_gap_max = 2;
        default: send_gap_max = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_gap_max = 0;
        1:       recv_gap_max = 2;
        default: recv_gap_max = 12;
      endcase
      style = weight_style_t'($urandom_range(0, 2));
      if (tap_span() == 0 || $urandom_range(0, 2) == 0) begin
        taps = ($urandom_range(0, 4) == 0) ? $urandom_range(17, TAP_SLOTS)
                                           : $urandom_range(1, 16);
        for (int i = 0; i < taps; i++) send_tap(i, make_weight(style));
      end
      span = tap_span();
      if ($urandom_range(0, 4) == 0) len = span + $urandom_range(0, 8);
      else len = $urandom_range(1, 16);
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(4080, 4095)
                                         : $urandom_range(0, LINE_LEN - 1);
      for (int j = 0; j < len; j++) begin
        send_pixel((base + j) % LINE_LEN, make_color());
        if ($urandom_range(0, 15) == 0) send_nop();
      end
      repeat ($urandom_range(1, 8)) begin
        max_count = (span < len) ? span : len;
        count     = $urandom_range(0, max_count);
        if (max_count == TAP_SLOTS && $urandom_range(0, 2) == 0) begin
          count = $urandom_range(TAP_SLOTS, 127);
        end
        taps  = (count > TAP_SLOTS) ? TAP_SLOTS : count;
        start = (base + $urandom_range(0, len - taps)) % LINE_LEN;
        // A write to the very pixel or tap about to be read checks that the
        // store hands back the newest data.
        if (taps > 0 && $urandom_range(0, 3) == 0) begin
          send_pixel((start + $urandom_range(0, taps - 1)) % LINE_LEN, make_color());
        end
        if (span > 0 && $urandom_range(0, 5) == 0) begin
          send_tap($urandom_range(0, span - 1), make_weight(style));
        end
        if ($urandom_range(0, 7) == 0) send_nop();
        if ($urandom_range(0, 9) == 0) send_pixel($urandom_range(0, LINE_LEN - 1), make_color());
        send_resample(start, count);
      end
      bursts++;
      if (bursts % 8 == 0) wait_results_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d, cycle %0d)",
             what, got, want, pixels_checked, cycle_count);
    mismatches++;
  endtask

  // The receiver waits a random number of cycles before each word, or the
  // long hold-off when one is requested.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        n               = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = $urandom_range(0, recv_gap_max);
      end
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Every word taken from the output is checked against the oldest expected
  // pixel, one channel at a time.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing expected", {out_red, out_green, out_blue}, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        pixels_checked++;
      end
    end
  end

  // Cycle count, stall statistics and the run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid === 1'b1 && in_stall === 1'b1) input_held++;
    if (out_valid === 1'b1 && out_stall === 1'b1) output_held++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("lanczos_line_resampler regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_NONE;
    in_pixel_position = '0;
    in_red            = '0;
    in_green          = '0;
    in_blue           = '0;
    in_tap_index      = '0;
    in_tap_weight     = '0;
    in_window_start   = '0;
    in_tap_count      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_window();
    test_backpressure();
    test_random_bursts();

    // Let the last computes finish, then watch for stray results.
    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk);

    $display("Sent %0d words, checked %0d pixels, %0d wrapped windows, %0d saturated counts.",
             words_sent, pixels_checked, wrap_windows, saturated_windows);
    $display("Input stalled %0d cycles, output held %0d cycles, %0d mismatches.",
             input_held, output_held, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("lanczos_line_resampler regression: pass");
    end else begin
      $display("lanczos_line_resampler regression: fail");
    end
    $finish;
  end

endmodule
